[design/uvs_pkg.sv]
// uvs_pkg: shared constants and types of the uv sphere vertex generator
// no dependencies; used by uvs_table, uvs_recip and the top level
`default_nettype none

package uvs_pkg;

  localparam int ANGLE_BITS    = 12;
  localparam int QUARTER_UNITS = 1 << (ANGLE_BITS - 2);
  localparam int TAB_DEPTH     = QUARTER_UNITS + 1;
  localparam int TAB_ADDR_BITS = ANGLE_BITS - 1;
  localparam int SINE_BITS     = 15;
  localparam int TRIG_BITS     = 16;

  localparam int COUNT_BITS    = 8;
  localparam int FRAC_BITS     = 18;
  localparam int QUO_BITS      = FRAC_BITS + 1;
  localparam int DIV_STEP      = 3;
  localparam int DIV_CYCLES    = FRAC_BITS / DIV_STEP;

  localparam int REG_INDEX_BITS = 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_RADIUS        = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_RING_COUNT    = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_SEGMENT_COUNT = 2'd2;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    logic                  rd;
    logic [ANGLE_BITS-1:0] angle;
  } tab_req_t;

endpackage

`default_nettype wire

[design/uvs_ram.sv]
// uvs_ram: generic single-port ram with registered read data
// no dependencies
`default_nettype none

module uvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [WIDTH-1:0]     wdata,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[design/uvs_table.sv]
// uvs_table: quarter-wave sine table in ram, filled after reset by a polynomial
// sequencer on one shared multiplier, then read with quadrant folding
// depends on uvs_pkg and uvs_ram
`default_nettype none

module uvs_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire uvs_pkg::tab_req_t req,
  output uvs_pkg::trig_t         rsp,
  output logic                   ready
);

  localparam int AB      = uvs_pkg::ANGLE_BITS;
  localparam int TA      = uvs_pkg::TAB_ADDR_BITS;
  localparam int SB      = uvs_pkg::SINE_BITS;
  localparam int X_SHIFT = 32 - AB;

  localparam logic [30:0] PC1 = 31'd1686629713;
  localparam logic [30:0] PC3 = 31'd693598668;
  localparam logic [30:0] PC5 = 31'd85569306;
  localparam logic [30:0] PC7 = 31'd5026995;
  localparam logic [30:0] PC9 = 31'd172273;

  localparam logic [TA-1:0] LAST_ENTRY = TA'(uvs_pkg::QUARTER_UNITS);
  localparam logic [SB-1:0] ONE_Q14    = SB'(16384);

  typedef enum logic [2:0] {
    T_SQ, T_X2, T_MH, T_SH, T_MS, T_WR, T_RUN
  } tstate_t;

  tstate_t       state;
  logic [TA-1:0] n;
  logic [1:0]    k;
  logic [30:0]   x;
  logic [30:0]   x2;
  logic [30:0]   p;
  logic [61:0]   prod;
  logic [30:0]   mul_a;
  logic [30:0]   mul_b;
  logic [31:0]   hi;
  logic [31:0]   p_next;
  logic [16:0]   rounded;
  logic [SB-1:0] entry;
  logic          neg;
  logic [1:0]    quad;
  logic [TA-2:0] off;
  logic [TA-1:0] rd_addr;
  logic [TA-1:0] addr;
  logic [SB-1:0] rdata;

  function automatic logic [30:0] coef(input logic [1:0] idx);
    case (idx)
      2'd0:    return PC7;
      2'd1:    return PC5;
      2'd2:    return PC3;
      default: return PC1;
    endcase
  endfunction

  assign x = {n, {X_SHIFT{1'b0}}};
  assign hi = prod[61:30];
  assign p_next = {1'b0, coef(k)} - hi;
  assign rounded = 17'(({1'b0, hi} + 33'd32768) >> 16);
  assign entry = (rounded > 17'(ONE_Q14)) ? ONE_Q14 : rounded[SB-1:0];

  always_comb begin
    case (state)
      T_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      T_MH: begin
        mul_a = p;
        mul_b = x2;
      end
      default: begin
        mul_a = p;
        mul_b = x;
      end
    endcase
  end

  // quadrant folding onto the quarter wave
  assign quad = req.angle[AB-1 -: 2];
  assign off = req.angle[AB-3:0];
  assign rd_addr = quad[0] ? (LAST_ENTRY - {1'b0, off}) : {1'b0, off};
  assign addr = (state == T_RUN) ? rd_addr : n;

  uvs_ram #(
    .WIDTH(SB),
    .DEPTH(uvs_pkg::TAB_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (state == T_WR),
    .addr (addr),
    .wdata(entry),
    .rdata(rdata)
  );

  assign rsp = neg ? -uvs_pkg::trig_t'({1'b0, rdata}) : uvs_pkg::trig_t'({1'b0, rdata});
  assign ready = (state == T_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_SQ;
      n <= '0;
      k <= '0;
    end else begin
      case (state)
        T_SQ: begin
          prod <= mul_a * mul_b;
          state <= T_X2;
        end
        T_X2: begin
          x2 <= prod[60:30];
          p <= PC9;
          k <= '0;
          state <= T_MH;
        end
        T_MH: begin
          prod <= mul_a * mul_b;
          state <= T_SH;
        end
        T_SH: begin
          p <= p_next[30:0];
          k <= k + 2'd1;
          state <= (k == 2'd3) ? T_MS : T_MH;
        end
        T_MS: begin
          prod <= mul_a * mul_b;
          state <= T_WR;
        end
        T_WR: begin
          n <= n + TA'(1);
          state <= (n == LAST_ENTRY) ? T_RUN : T_SQ;
        end
        T_RUN: begin
          if (req.rd) begin
            neg <= quad[1];
          end
        end
        default: begin
          state <= T_SQ;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/uvs_recip.sv]
// uvs_recip: two lanes of fraction division, index over count, several bits a cycle
// depends on uvs_pkg
`default_nettype none

module uvs_recip (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [uvs_pkg::COUNT_BITS-1:0]      ring_num,
  input  wire logic [uvs_pkg::COUNT_BITS-1:0]      ring_den,
  input  wire logic [uvs_pkg::COUNT_BITS-1:0]      seg_num,
  input  wire logic [uvs_pkg::COUNT_BITS-1:0]      seg_den,
  output logic                                     done,
  output logic      [uvs_pkg::QUO_BITS-1:0]        ring_quo,
  output logic      [uvs_pkg::QUO_BITS-1:0]        seg_quo
);

  localparam int CB       = uvs_pkg::COUNT_BITS;
  localparam int QB       = uvs_pkg::QUO_BITS;
  localparam int CNT_BITS = $clog2(uvs_pkg::DIV_CYCLES + 1);

  logic [CB-1:0]       ring_rem;
  logic [CB-1:0]       seg_rem;
  logic [CB-1:0]       ring_d;
  logic [CB-1:0]       seg_d;
  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [CB+QB-1:0]    ring_step;
  logic [CB+QB-1:0]    seg_step;

  function automatic logic [CB+QB-1:0] div_steps(input logic [CB-1:0] rem,
                                                  input logic [CB-1:0] den,
                                                  input logic [QB-1:0] quo);
    logic [CB:0]   r2;
    logic [CB-1:0] r;
    logic [QB-1:0] q;
    r = rem;
    q = quo;
    for (int s = 0; s < uvs_pkg::DIV_STEP; s++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, den}) begin
        r = CB'(r2 - {1'b0, den});
        q = {q[QB-2:0], 1'b1};
      end else begin
        r = r2[CB-1:0];
        q = {q[QB-2:0], 1'b0};
      end
    end
    return {r, q};
  endfunction

  assign ring_step = div_steps(ring_rem, ring_d, ring_quo);
  assign seg_step = div_steps(seg_rem, seg_d, seg_quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(uvs_pkg::DIV_CYCLES);
        ring_d <= ring_den;
        seg_d <= seg_den;
        ring_rem <= (ring_num == ring_den) ? '0 : ring_num;
        seg_rem <= (seg_num == seg_den) ? '0 : seg_num;
        ring_quo <= QB'(ring_num == ring_den);
        seg_quo <= QB'(seg_num == seg_den);
      end else if (busy) begin
        {ring_rem, ring_quo} <= ring_step;
        {seg_rem, seg_quo} <= seg_step;
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/uv_sphere_vertex_generator_unit.sv]
// uv_sphere_vertex_generator_unit: top level, vertex walk, sequencer, multiplier, output beat
// depends on uvs_pkg, uvs_table and uvs_recip
//
// Emits one uv sphere vertex per input beat, rings outer and segments inner, with
// Q8.8 position, Q1.14 normal, Q1.16 texture coordinates and the triangle base index.
// After reset the sine table is filled first, all 1025 of its entries, during which
// s_tready stays low (config writes are taken). Then each vertex passes from accept
// to the result beat through the fraction divider, four reads through the single
// table port and five passes through the shared multiplier. One vertex is in flight
// at a time; a finished beat waits in the output register while the next vertex is
// taken.
`default_nettype none

module uv_sphere_vertex_generator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,   // restart
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, tri_base
  output logic      [151:0]                         m_tdata,
  output logic                                      m_tuser,   // tri_valid
  output logic                                      m_tlast,   // last_vertex
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [uvs_pkg::REG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [15:0]                          cfg_data
);

  localparam int AB = uvs_pkg::ANGLE_BITS;
  localparam int CB = uvs_pkg::COUNT_BITS;
  localparam int QB = uvs_pkg::QUO_BITS;
  localparam int FB = uvs_pkg::FRAC_BITS;
  localparam logic [AB-1:0] QUARTER = AB'(uvs_pkg::QUARTER_UNITS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_LOOK0, ST_LOOK1, ST_LOOK2, ST_LOOK3,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_DONE
  } state_t;

  state_t               state;
  logic [15:0]          radius;
  logic [CB-1:0]        ring_count;
  logic [CB-1:0]        segment_count;
  logic [CB-1:0]        ring_index;
  logic [CB-1:0]        segment_index;
  logic [15:0]          tri_count;

  logic [CB-1:0]        rc;
  logic [CB-1:0]        sc;
  logic                 walk_restart;
  logic [CB-1:0]        cur_i;
  logic [CB-1:0]        cur_j;
  logic [15:0]          cur_cnt;
  logic                 cur_valid;
  logic                 cur_last;
  logic [CB-1:0]        ring_index_next;
  logic [CB-1:0]        segment_index_next;
  logic [15:0]          tri_count_next;
  logic                 s_accept;
  logic                 out_free;

  logic                 w_valid;
  logic                 w_last;
  logic [15:0]          w_base;
  logic [AB-1:0]        a_ang;
  logic [AB-1:0]        b_ang;
  logic [16:0]          tex_u;
  logic [16:0]          tex_v;
  uvs_pkg::trig_t       sa;
  uvs_pkg::trig_t       ca;
  uvs_pkg::trig_t       sb;
  uvs_pkg::trig_t       cb;
  logic signed [29:0]   tx;
  logic signed [29:0]   tz;
  logic signed [15:0]   px;
  logic signed [15:0]   py;
  logic signed [15:0]   pz;
  logic signed [15:0]   nx;
  logic signed [15:0]   nz;
  logic signed [16:0]   mul_a;
  logic signed [29:0]   mul_b;
  logic signed [46:0]   prod;

  uvs_pkg::tab_req_t    tab_req;
  uvs_pkg::trig_t       tab_rsp;
  logic                 tab_ready;
  logic                 div_done;
  logic [QB-1:0]        ring_quo;
  logic [QB-1:0]        seg_quo;

  function automatic logic signed [15:0] round_sat(input logic signed [46:0] v,
                                                   input int sh);
    logic [46:0]        mag;
    logic [46:0]        r;
    logic signed [47:0] sv;
    mag = v[46] ? 47'(-v) : 47'(v);
    r = (mag + (47'(1) << (sh - 1))) >> sh;
    sv = v[46] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (sv > 48'sd32767) begin
      return 16'sh7fff;
    end else if (sv < -48'sd32768) begin
      return 16'sh8000;
    end
    return sv[15:0];
  endfunction

  function automatic logic [QB-1:0] round_q(input logic [QB-1:0] q, input int drop);
    return ((q >> drop) + QB'(1)) >> 1;
  endfunction

  // vertex walk
  always_comb begin
    rc = (ring_count == '0) ? CB'(1) : ring_count;
    sc = (segment_count == '0) ? CB'(1) : segment_count;
    walk_restart = s_tdata[0] || (ring_index > rc) || (segment_index > sc);
    cur_i = walk_restart ? '0 : ring_index;
    cur_j = walk_restart ? '0 : segment_index;
    cur_cnt = walk_restart ? '0 : tri_count;
    cur_valid = (cur_i != rc);
    cur_last = (cur_i == rc) && (cur_j == sc);
    tri_count_next = cur_valid ? cur_cnt + 16'd1 : cur_cnt;
    ring_index_next = cur_i;
    if (cur_j < sc) begin
      segment_index_next = cur_j + CB'(1);
    end else begin
      segment_index_next = '0;
      if (cur_i < rc) begin
        ring_index_next = cur_i + CB'(1);
      end else begin
        ring_index_next = '0;
        tri_count_next = '0;
      end
    end
  end

  assign s_tready = (state == ST_IDLE) && tab_ready;
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  uvs_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (s_accept),
    .ring_num(cur_i),
    .ring_den(rc),
    .seg_num (cur_j),
    .seg_den (sc),
    .done    (div_done),
    .ring_quo(ring_quo),
    .seg_quo (seg_quo)
  );

  always_comb begin
    case (state)
      ST_LOOK0: tab_req = '{rd: 1'b1, angle: a_ang};
      ST_LOOK1: tab_req = '{rd: 1'b1, angle: a_ang + QUARTER};
      ST_LOOK2: tab_req = '{rd: 1'b1, angle: b_ang};
      ST_LOOK3: tab_req = '{rd: 1'b1, angle: b_ang + QUARTER};
      default:  tab_req = '{rd: 1'b0, angle: a_ang};
    endcase
  end

  uvs_table u_table (
    .clk  (clk),
    .rst  (rst),
    .req  (tab_req),
    .rsp  (tab_rsp),
    .ready(tab_ready)
  );

  // shared multiplier operands
  always_comb begin
    case (state)
      ST_MUL0: begin
        mul_a = 17'(sa);
        mul_b = 30'(sb);
      end
      ST_MUL1: begin
        mul_a = 17'(sa);
        mul_b = 30'(cb);
      end
      ST_MUL2: begin
        mul_a = $signed({1'b0, radius});
        mul_b = 30'(ca);
      end
      ST_MUL3: begin
        mul_a = $signed({1'b0, radius});
        mul_b = tx;
      end
      default: begin
        mul_a = $signed({1'b0, radius});
        mul_b = tz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      radius <= 16'd2560;
      ring_count <= CB'(32);
      segment_count <= CB'(32);
      ring_index <= '0;
      segment_index <= '0;
      tri_count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          uvs_pkg::REG_RADIUS:        radius <= cfg_data;
          uvs_pkg::REG_RING_COUNT:    ring_count <= cfg_data[CB-1:0];
          uvs_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data[CB-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            ring_index <= ring_index_next;
            segment_index <= segment_index_next;
            tri_count <= tri_count_next;
            w_valid <= cur_valid;
            w_last <= cur_last;
            w_base <= cur_valid ? cur_cnt : '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            a_ang <= AB'(round_q(ring_quo, FB - AB));
            b_ang <= AB'(round_q(seg_quo, FB - AB - 1));
            tex_u <= 17'(round_q(seg_quo, FB - 17));
            tex_v <= 17'(round_q(ring_quo, FB - 17));
            state <= ST_LOOK0;
          end
        end
        ST_LOOK0: state <= ST_LOOK1;
        ST_LOOK1: begin
          sa <= tab_rsp;
          state <= ST_LOOK2;
        end
        ST_LOOK2: begin
          ca <= tab_rsp;
          state <= ST_LOOK3;
        end
        ST_LOOK3: begin
          sb <= tab_rsp;
          state <= ST_MUL0;
        end
        ST_MUL0: begin
          cb <= tab_rsp;
          prod <= mul_a * mul_b;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          tx <= prod[29:0];
          nx <= round_sat(prod, 14);
          prod <= mul_a * mul_b;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          tz <= prod[29:0];
          nz <= round_sat(prod, 14);
          prod <= mul_a * mul_b;
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          py <= round_sat(prod, 14);
          prod <= mul_a * mul_b;
          state <= ST_MUL4;
        end
        ST_MUL4: begin
          px <= round_sat(prod, 28);
          prod <= mul_a * mul_b;
          state <= ST_MUL5;
        end
        ST_MUL5: begin
          pz <= round_sat(prod, 28);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser <= w_valid;
            m_tlast <= w_last;
            if (radius == 16'd0) begin
              m_tdata <= {6'b0, w_base, tex_v, tex_u, 48'd0, pz, py, px};
            end else begin
              m_tdata <= {6'b0, w_base, tex_v, tex_u, nz, ca, nx, pz, py, px};
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/uvs_vertex_checker.sv]
// uvs_vertex_checker: watches the config, input and vertex channels of the uv sphere unit,
// predicts every vertex beat from its own walk state and compares it field by field
// depends on uvs_pkg for the angle and register index constants
`timescale 1ns / 1ps

module uvs_vertex_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  input  wire logic                               s_tready,
  input  wire logic [7:0]                         s_tdata,   // restart
  input  wire logic                               m_tvalid,
  input  wire logic                               m_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, tri_base
  input  wire logic [151:0]                       m_tdata,
  input  wire logic                               m_tuser,   // tri_valid
  input  wire logic                               m_tlast,   // last_vertex
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready,
  input  wire logic [uvs_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [15:0]                        cfg_data,
  output int                                      fail_count,
  output int                                      beats_seen,
  output int                                      backlog
);

  import uvs_pkg::*;

  localparam int unsigned FULL_MASK = (1 << ANGLE_BITS) - 1;
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = 64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = 64'sd5026995;
  localparam longint SIN_C9 = 64'sd172273;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        tri_base;
    logic               tri_valid;
    logic               last_vertex;
  } vertex_t;

  vertex_t     expected_vertices[$];
  logic [15:0] radius_q;
  logic [7:0]  rings_q;
  logic [7:0]  segs_q;
  logic [7:0]  ring_at;
  logic [7:0]  seg_at;
  logic [15:0] tri_count;

  initial begin
    fail_count = 0;
    beats_seen = 0;
    backlog    = 0;
  end

  // quarter-wave entry, polynomial in q1.30 rounded to q1.14
  function automatic longint quarter_sine(int unsigned n);
    longint x, x2, p, s;
    x  = longint'(n) << (32 - ANGLE_BITS);
    x2 = (x * x) >>> 30;
    p  = SIN_C9;
    p  = SIN_C7 - ((p * x2) >>> 30);
    p  = SIN_C5 - ((p * x2) >>> 30);
    p  = SIN_C3 - ((p * x2) >>> 30);
    p  = SIN_C1 - ((p * x2) >>> 30);
    s  = (p * x) >>> 30;
    s  = (s + 32768) >>> 16;
    return (s > 16384) ? 64'sd16384 : s;
  endfunction

  function automatic longint sine_at(int unsigned t);
    int unsigned q, off;
    longint v;
    q   = (t & FULL_MASK) >> (ANGLE_BITS - 2);
    off = t & (QUARTER_UNITS - 1);
    v   = q[0] ? quarter_sine(QUARTER_UNITS - off) : quarter_sine(off);
    return q[1] ? -v : v;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v < 0) return -(((-v) + half) >>> sh);
    return (v + half) >>> sh;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // advance the sphere walk by one vertex and return what the unit must emit
  function automatic vertex_t next_vertex(bit restart);
    int unsigned rc, sc, i, j, a, b;
    longint sa, ca, sb, cb, rad;
    vertex_t v;
    rc = (rings_q == 0) ? 1 : rings_q;
    sc = (segs_q == 0) ? 1 : segs_q;
    if (restart || ring_at > rc || seg_at > sc) begin
      ring_at   = 0;
      seg_at    = 0;
      tri_count = 0;
    end
    i   = ring_at;
    j   = seg_at;
    a   = (i * (1 << ANGLE_BITS) + rc) / (2 * rc);
    b   = ((j * (2 << ANGLE_BITS) + sc) / (2 * sc)) & FULL_MASK;
    sa  = sine_at(a);
    ca  = sine_at((a + QUARTER_UNITS) & FULL_MASK);
    sb  = sine_at(b);
    cb  = sine_at((b + QUARTER_UNITS) & FULL_MASK);
    rad = longint'(radius_q);
    v.pos_x = sat16(round_shift(rad * sa * sb, 28));
    v.pos_y = sat16(round_shift(rad * ca, 14));
    v.pos_z = sat16(round_shift(rad * sa * cb, 28));
    if (radius_q == 0) begin
      v.norm_x = '0;
      v.norm_y = '0;
      v.norm_z = '0;
    end else begin
      v.norm_x = sat16(round_shift(sa * sb, 14));
      v.norm_y = sat16(ca);
      v.norm_z = sat16(round_shift(sa * cb, 14));
    end
    v.tex_u       = 17'((j * 131072 + sc) / (2 * sc));
    v.tex_v       = 17'((i * 131072 + rc) / (2 * rc));
    v.tri_valid   = (i != rc);
    v.last_vertex = (i == rc) && (j == sc);
    v.tri_base    = v.tri_valid ? tri_count : 16'd0;
    if (v.tri_valid) tri_count = tri_count + 16'd1;
    if (j < sc) begin
      seg_at = 8'(j + 1);
    end else begin
      seg_at = 0;
      if (i < rc) begin
        ring_at = 8'(i + 1);
      end else begin
        ring_at   = 0;
        tri_count = 0;
      end
    end
    return v;
  endfunction

  function automatic string show_vertex(vertex_t v);
    return $sformatf("pos %0d %0d %0d norm %0d %0d %0d uv %0d %0d tri %0d/%0b last %0b",
                     v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z,
                     v.tex_u, v.tex_v, v.tri_base, v.tri_valid, v.last_vertex);
  endfunction

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst) begin
      radius_q  = 16'd2560;
      rings_q   = 8'd32;
      segs_q    = 8'd32;
      ring_at   = 0;
      seg_at    = 0;
      tri_count = 0;
      expected_vertices.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS:        radius_q = cfg_data;
          REG_RING_COUNT:    rings_q  = cfg_data[7:0];
          REG_SEGMENT_COUNT: segs_q   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.pos_x       = m_tdata[15:0];
        got.pos_y       = m_tdata[31:16];
        got.pos_z       = m_tdata[47:32];
        got.norm_x      = m_tdata[63:48];
        got.norm_y      = m_tdata[79:64];
        got.norm_z      = m_tdata[95:80];
        got.tex_u       = m_tdata[112:96];
        got.tex_v       = m_tdata[129:113];
        got.tri_base    = m_tdata[145:130];
        got.tri_valid   = m_tuser;
        got.last_vertex = m_tlast;
        if (expected_vertices.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected vertex beat %0d: %s", beats_seen, show_vertex(got));
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("vertex mismatch at beat %0d", beats_seen);
              $display("  expected %s", show_vertex(want));
              $display("  actual   %s", show_vertex(got));
            end
          end
        end
        beats_seen++;
      end
      if (s_tvalid && s_tready) expected_vertices.push_back(next_vertex(s_tdata[0]));
    end
    backlog = expected_vertices.size();
  end

endmodule

[tb/tb_uv_sphere_vertex_generator_unit.sv]
// tb_uv_sphere_vertex_generator_unit: stimulus and verdict for the uv sphere vertex unit
// depends on uvs_pkg, uv_sphere_vertex_generator_unit and uvs_vertex_checker
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator_unit;

  import uvs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [REG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata   = 8'd0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [151:0]              m_tdata;
  logic                      m_tuser;
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [REG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0]               cfg_data  = 16'd0;

  int fail_count;
  int beats_seen;
  int backlog;
  int items_sent = 0;
  int cycle_count = 0;
  int rdy_hold = 0;
  bit quiet = 1'b0;

  uv_sphere_vertex_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uvs_vertex_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .beats_seen (beats_seen),
    .backlog    (backlog)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // vertex sink back-pressure
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      m_tready <= 1'b1;
      rdy_hold <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b0;
      rdy_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(0, 3);
    end
  end

  task automatic write_reg(logic [REG_INDEX_BITS-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(bit restart);
    int gap;
    int r;
    gap = 0;
    r = $urandom_range(0, 19);
    if (!quiet && r >= 9) gap = (r < 18) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (beats_seen != items_sent);
  endtask

  function automatic logic [15:0] pick_count();
    int r;
    logic [7:0] cnt;
    r = $urandom_range(0, 9);
    if (r == 0) cnt = 8'd0;
    else if (r == 1) cnt = 8'd1;
    else if (r == 2) cnt = 8'd255;
    else if (r < 8) cnt = 8'($urandom_range(1, 6));
    else cnt = 8'($urandom_range(0, 255));
    return {8'($urandom_range(0, 255)), cnt};
  endfunction

  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // largest radius saturates, zero segment count acts as one, upper data bits ignored
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_RING_COUNT, 16'hAB01);
    write_reg(REG_SEGMENT_COUNT, 16'h5400);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    drain();

    // zero radius, walk into the second ring
    write_reg(REG_RADIUS, 16'h0000);
    write_reg(REG_RING_COUNT, 16'h0002);
    write_reg(REG_SEGMENT_COUNT, 16'h0003);
    repeat (7) send_beat(1'b0);
    drain();

    // segment count shrinks to one on the last ring, so the walk wraps back to the start
    write_reg(REG_RADIUS, 16'h012C);
    write_reg(REG_SEGMENT_COUNT, 16'h0001);
    repeat (3) send_beat(1'b0);
    drain();

    write_reg(REG_RADIUS, 16'h7FFF);
    write_reg(REG_RING_COUNT, 16'h00FF);
    write_reg(REG_SEGMENT_COUNT, 16'h00FF);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    drain();

    while (items_sent < RANDOM_ITEMS + 19) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 5);
        if (r == 0) write_reg(REG_RADIUS, 16'h0000);
        else if (r == 1) write_reg(REG_RADIUS, 16'hFFFF);
        else if (r == 2) write_reg(REG_RADIUS, 16'($urandom_range(0, 65535)));
        else write_reg(REG_RADIUS, 16'($urandom_range(0, 4096)));
      end
      if ($urandom_range(0, 2) != 0) write_reg(REG_RING_COUNT, pick_count());
      if ($urandom_range(0, 2) != 0) write_reg(REG_SEGMENT_COUNT, pick_count());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
      repeat ($urandom_range(8, 60)) send_beat($urandom_range(0, 29) == 0);
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
